### hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWOF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SWOF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/swof_pkg.sv
package swof_pkg;

   localparam int MAX_WINDOW  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int PTR_W       = $clog2(MAX_WINDOW);
   localparam int CNT_W       = PTR_W + 1;
   localparam int SUM_W       = SAMPLE_BITS + CNT_W;
   localparam int SQ_W        = 2 * SAMPLE_BITS + CNT_W;
   localparam int DQ_W        = SQ_W + CNT_W;
   localparam int DH_W        = (DQ_W + 1) / 2;
   localparam int THR_W       = 16;
   localparam int T2_W        = 2 * THR_W;
   localparam int RHS_W       = T2_W + DQ_W + 1;
   localparam int LHS_W       = 2 * SUM_W + 16;
   localparam int DIVD_W      = SUM_W + 1;
   localparam int DIVS_W      = CNT_W + 1;
   localparam int DIVC_W      = $clog2(DIVD_W + 1);
   localparam int HNUM_W      = 22;
   localparam int HDEN_W      = 14;
   localparam int HL_W        = SAMPLE_BITS + HNUM_W;
   localparam int HR1_W       = THR_W + HDEN_W;
   localparam int HR_W        = HR1_W + SAMPLE_BITS;
   localparam int RAM_W       = SAMPLE_BITS + 1;

   localparam logic [HNUM_W-1:0] HAMPEL_NUM = 22'd2560000;
   localparam logic [HDEN_W-1:0] HAMPEL_DEN = 14'd14826;

   typedef logic [2:0] reg_addr_type;
   localparam reg_addr_type REG_ENABLE = 3'd0;
   localparam reg_addr_type REG_MODE   = 3'd1;
   localparam reg_addr_type REG_WINDOW = 3'd2;
   localparam reg_addr_type REG_HTHR   = 3'd3;
   localparam reg_addr_type REG_ZTHR   = 3'd4;

   typedef enum logic [1:0] {PASS_MED, PASS_MAD, PASS_SUM} pass_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

endpackage

### hdl/swof_ram.sv
module swof_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hdl/swof_div.sv
module swof_div (
   input  logic                            clock,
   input  logic                            reset,
   input  swof_pkg::div_req_type           div_req,
   output logic                            div_done,
   output logic [swof_pkg::DIVD_W-1:0]     div_quot
);
   import swof_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVC_W-1:0] cnt_ff, cnt_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dsr_ff, dsr_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = DIVC_W'(DIVD_W);
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIVS_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIVC_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign div_quot = quo_ff;

endmodule

### hdl/sliding_window_outlier_filter.sv
// Sliding-window outlier filter.
// Input channel req_*: one 16-bit sample and its spike flag per item, taken
// when req_valid is high and req_stall low. Result channel rsp_*: zero or
// one result item per input item, held in an output register until taken
// (rsp_valid high, rsp_stall low). Configuration goes through the csr_* APB
// port; any write to a defined register empties the ring (write pointer and
// fill count) and clears the four statistics counters.
// One item is worked on at a time; req_stall is high while it is in work.
// A new item is taken while the previous result still waits on rsp_stall.
// Pass-through (filter disabled): the sample goes unchanged to the result.
// Window not yet full: the sample is stored, no result, the filter stays idle.
// Hampel mode: two rank-count searches over the ring (median, then MAD);
// each candidate is counted against the whole window through the single
// read port, then the Hampel test and, for an outlier, a median write-back.
// Z-score mode: one sweep over the window, then the 23-step serial divider
// for the rounded mean.
// Reset restores the default registers and empties the window; nothing is
// emitted until the window has refilled.
module sliding_window_outlier_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sample,
   input  logic        req_spike_flag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_sample,
   output logic        rsp_replaced,
   output logic [31:0] rsp_true_pos_count,
   output logic [31:0] rsp_false_pos_count,
   output logic [31:0] rsp_true_neg_count,
   output logic [31:0] rsp_false_neg_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import swof_pkg::*;
`include "assert_macros.svh"

   typedef enum logic [18:0] {
      S_IDLE     = 19'h00001,
      S_CENTRE   = 19'h00002,
      S_CENTRE_W = 19'h00004,
      S_CAND     = 19'h00008,
      S_CAND_W   = 19'h00010,
      S_SWEEP    = 19'h00020,
      S_RANK     = 19'h00040,
      S_H1       = 19'h00080,
      S_H2       = 19'h00100,
      S_H3       = 19'h00200,
      S_Z1       = 19'h00400,
      S_Z2       = 19'h00800,
      S_Z3       = 19'h01000,
      S_Z4       = 19'h02000,
      S_Z5       = 19'h04000,
      S_Z6       = 19'h08000,
      S_WB       = 19'h10000,
      S_OUT      = 19'h20000,
      S_SPARE    = 19'h40000
   } state_type;

   // configuration
   logic             en_ff, mode_ff;
   logic [15:0]      rwin_ff, hthr_ff, zthr_ff;
   logic             cfg_wr, cfg_hit;
   reg_addr_type     cfg_idx;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in, start_ff, start_in;
   logic [CNT_W-1:0] fill_ff, fill_in, fill_next;
   logic [31:0]      tp_ff, tp_in, fp_ff, fp_in, tn_ff, tn_in, fnc_ff, fnc_in;
   logic [CNT_W-1:0] win_n, win_k;

   pass_type         pass_ff, pass_in;
   logic [CNT_W-1:0] ci_ff, ci_in, j_ff, j_in, p_ff, p_in, lt_ff, lt_in, le_ff, le_in;
   logic             pend_ff, pend_in;
   logic [SAMPLE_BITS-1:0] x_ff, x_in, cand_ff, cand_in, med_ff, med_in, mad_ff, mad_in;
   logic [SAMPLE_BITS-1:0] repl_ff, repl_in, v;
   logic             spk_ff, spk_in, outl_ff, outl_in;
   logic [SUM_W-1:0] s_ff, s_in;
   logic [SQ_W-1:0]  q_ff, q_in;
   logic [DQ_W-1:0]  dq_ff, dq_in, d_ff, d_in;
   logic [2*SUM_W-1:0] ss_ff, ss_in, lz_ff, lz_in;
   logic [SUM_W-1:0] cx_ff, cx_in, dev_ff, dev_in;
   logic [T2_W-1:0]  t2_ff, t2_in;
   logic [T2_W+DH_W-1:0] plo_ff, plo_in;
   logic [T2_W+DQ_W-DH_W-1:0] phi_ff, phi_in;
   logic [HL_W-1:0]  hl_ff, hl_in;
   logic [HR1_W-1:0] hr1_ff, hr1_in;
   logic [HR_W-1:0]  hr_ff, hr_in;
   logic [SAMPLE_BITS-1:0] hdev;
   logic [RHS_W-1:0] zrhs;
   logic [LHS_W-1:0] zlhs;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      o_sample_ff, o_sample_in;
   logic             o_outl_ff, o_outl_in;
   logic [31:0]      o_tp_ff, o_tp_in, o_fp_ff, o_fp_in, o_tn_ff, o_tn_in, o_fn_ff, o_fn_in;

   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr, ram_raddr;
   logic [RAM_W-1:0] ram_wdata, ram_rdata;
   logic [SAMPLE_BITS-1:0] rd_sample;

   div_req_type      div_req;
   logic             div_done;
   logic [DIVD_W-1:0] div_quot;

   logic             req_acc;

   swof_ram #(.DEPTH(MAX_WINDOW), .WIDTH(RAM_W)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   swof_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx    = csr_paddr[4:2];
   assign cfg_hit    = (cfg_idx == REG_ENABLE) || (cfg_idx == REG_MODE) ||
                       (cfg_idx == REG_WINDOW) || (cfg_idx == REG_HTHR) ||
                       (cfg_idx == REG_ZTHR);
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (cfg_idx)
         REG_ENABLE: csr_prdata = {31'd0, en_ff};
         REG_MODE:   csr_prdata = {31'd0, mode_ff};
         REG_WINDOW: csr_prdata = {16'd0, rwin_ff};
         REG_HTHR:   csr_prdata = {16'd0, hthr_ff};
         REG_ZTHR:   csr_prdata = {16'd0, zthr_ff};
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (rwin_ff < 16'd3) begin
         win_n = CNT_W'(3);
      end else if (rwin_ff > 16'(MAX_WINDOW)) begin
         win_n = CNT_W'(MAX_WINDOW);
      end else begin
         win_n = rwin_ff[CNT_W-1:0];
      end
      if (!win_n[0]) begin
         win_n = win_n - 1'b1;
      end
   end
   assign win_k = win_n >> 1;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign fill_next = (fill_ff == CNT_W'(MAX_WINDOW)) ? fill_ff : fill_ff + 1'b1;
   assign rd_sample = ram_rdata[SAMPLE_BITS-1:0];

   always_comb begin
      if (pass_ff == PASS_MAD) begin
         v = (rd_sample > med_ff) ? rd_sample - med_ff : med_ff - rd_sample;
      end else begin
         v = rd_sample;
      end
   end

   assign hdev = (x_ff > med_ff) ? x_ff - med_ff : med_ff - x_ff;
   assign zlhs = {lz_ff, 16'd0};
   assign zrhs = (RHS_W'(phi_ff) << DH_W) + RHS_W'(plo_ff);

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      start_in  = start_ff;
      tp_in     = tp_ff;
      fp_in     = fp_ff;
      tn_in     = tn_ff;
      fnc_in    = fnc_ff;
      pass_in   = pass_ff;
      ci_in     = ci_ff;
      j_in      = j_ff;
      p_in      = p_ff;
      lt_in     = lt_ff;
      le_in     = le_ff;
      pend_in   = 1'b0;
      x_in      = x_ff;
      cand_in   = cand_ff;
      med_in    = med_ff;
      mad_in    = mad_ff;
      repl_in   = repl_ff;
      spk_in    = spk_ff;
      outl_in   = outl_ff;
      s_in      = s_ff;
      q_in      = q_ff;
      dq_in     = dq_ff;
      d_in      = d_ff;
      ss_in     = ss_ff;
      lz_in     = lz_ff;
      cx_in     = cx_ff;
      dev_in    = dev_ff;
      t2_in     = t2_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      hl_in     = hl_ff;
      hr1_in    = hr1_ff;
      hr_in     = hr_ff;
      ram_we    = 1'b0;
      ram_waddr = wp_ff;
      ram_wdata = {req_spike_flag, req_sample[SAMPLE_BITS-1:0]};
      ram_raddr = start_ff + win_k[PTR_W-1:0];
      div_req   = '0;
      div_req.dividend = DIVD_W'({s_ff, 1'b0}) + DIVD_W'(win_n - 1'b1);
      div_req.divisor  = DIVS_W'({win_n - 1'b1, 1'b0});

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_sample_in  = o_sample_ff;
      o_outl_in    = o_outl_ff;
      o_tp_in      = o_tp_ff;
      o_fp_in      = o_fp_ff;
      o_tn_in      = o_tn_ff;
      o_fn_in      = o_fn_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (!en_ff) begin
                  x_in     = req_sample[SAMPLE_BITS-1:0];
                  outl_in  = 1'b0;
                  state_in = S_OUT;
               end else begin
                  ram_we   = 1'b1;
                  wp_in    = wp_ff + 1'b1;
                  fill_in  = fill_next;
                  start_in = wp_ff + 1'b1 - win_n[PTR_W-1:0];
                  if (fill_next >= win_n) begin
                     state_in = S_CENTRE;
                  end
               end
            end
         end
         S_CENTRE: begin
            state_in = S_CENTRE_W;
         end
         S_CENTRE_W: begin
            x_in   = rd_sample;
            spk_in = ram_rdata[RAM_W-1];
            ci_in  = '0;
            j_in   = '0;
            p_in   = '0;
            s_in   = '0;
            q_in   = '0;
            if (mode_ff) begin
               pass_in  = PASS_SUM;
               state_in = S_SWEEP;
            end else begin
               pass_in  = PASS_MED;
               state_in = S_CAND;
            end
         end
         S_CAND: begin
            ram_raddr = start_ff + ci_ff[PTR_W-1:0];
            state_in  = S_CAND_W;
         end
         S_CAND_W: begin
            cand_in  = v;
            lt_in    = '0;
            le_in    = '0;
            j_in     = '0;
            p_in     = '0;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            ram_raddr = start_ff + j_ff[PTR_W-1:0];
            if (j_ff < win_n) begin
               j_in    = j_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               p_in = p_ff + 1'b1;
               if (pass_ff == PASS_SUM) begin
                  if (p_ff != win_k) begin
                     s_in = s_ff + SUM_W'(rd_sample);
                     q_in = q_ff + SQ_W'(rd_sample) * SQ_W'(rd_sample);
                  end
               end else begin
                  if (v < cand_ff) begin
                     lt_in = lt_ff + 1'b1;
                  end
                  if (v <= cand_ff) begin
                     le_in = le_ff + 1'b1;
                  end
               end
            end else if (j_ff == win_n) begin
               state_in = (pass_ff == PASS_SUM) ? S_Z1 : S_RANK;
            end
         end
         S_RANK: begin
            if (lt_ff <= win_k && le_ff > win_k) begin
               ci_in = '0;
               if (pass_ff == PASS_MED) begin
                  med_in   = cand_ff;
                  pass_in  = PASS_MAD;
                  state_in = S_CAND;
               end else begin
                  mad_in   = cand_ff;
                  state_in = S_H1;
               end
            end else begin
               ci_in    = ci_ff + 1'b1;
               state_in = S_CAND;
            end
         end
         S_H1: begin
            hl_in    = HL_W'(hdev) * HL_W'(HAMPEL_NUM);
            hr1_in   = HR1_W'(hthr_ff) * HR1_W'(HAMPEL_DEN);
            state_in = S_H2;
         end
         S_H2: begin
            hr_in    = HR_W'(hr1_ff) * HR_W'(mad_ff);
            state_in = S_H3;
         end
         S_H3: begin
            outl_in  = (mad_ff != '0) && (HR_W'(hl_ff) > hr_ff);
            repl_in  = med_ff;
            state_in = S_WB;
         end
         S_Z1: begin
            div_req.start = 1'b1;
            dq_in    = DQ_W'(q_ff) * DQ_W'(win_n - 1'b1);
            ss_in    = (2*SUM_W)'(s_ff) * (2*SUM_W)'(s_ff);
            cx_in    = SUM_W'(x_ff) * SUM_W'(win_n - 1'b1);
            state_in = S_Z2;
         end
         S_Z2: begin
            d_in     = dq_ff - DQ_W'(ss_ff);
            dev_in   = (cx_ff > s_ff) ? cx_ff - s_ff : s_ff - cx_ff;
            state_in = S_Z3;
         end
         S_Z3: begin
            lz_in    = (2*SUM_W)'(dev_ff) * (2*SUM_W)'(dev_ff);
            t2_in    = T2_W'(zthr_ff) * T2_W'(zthr_ff);
            state_in = S_Z4;
         end
         S_Z4: begin
            plo_in   = (T2_W+DH_W)'(t2_ff) * (T2_W+DH_W)'(d_ff[DH_W-1:0]);
            state_in = S_Z5;
         end
         S_Z5: begin
            phi_in   = (T2_W+DQ_W-DH_W)'(t2_ff) * (T2_W+DQ_W-DH_W)'(d_ff[DQ_W-1:DH_W]);
            state_in = S_Z6;
         end
         S_Z6: begin
            if (div_done) begin
               outl_in  = (d_ff != '0) && (RHS_W'(zlhs) > zrhs);
               repl_in  = div_quot[SAMPLE_BITS-1:0];
               state_in = S_WB;
            end
         end
         S_WB: begin
            ram_waddr = start_ff + win_k[PTR_W-1:0];
            ram_wdata = {spk_ff, repl_ff};
            if (outl_ff) begin
               ram_we = 1'b1;
               x_in   = repl_ff;
               if (spk_ff) begin
                  tp_in = tp_ff + 1'b1;
               end else begin
                  fp_in = fp_ff + 1'b1;
               end
            end else if (spk_ff) begin
               fnc_in = fnc_ff + 1'b1;
            end else begin
               tn_in = tn_ff + 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_sample_in  = 16'(x_ff);
               o_outl_in    = outl_ff;
               o_tp_in      = tp_ff;
               o_fp_in      = fp_ff;
               o_tn_in      = tn_ff;
               o_fn_in      = fnc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_wr && cfg_hit) begin
         wp_in   = '0;
         fill_in = '0;
         tp_in   = '0;
         fp_in   = '0;
         tn_in   = '0;
         fnc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff        <= 1'b1;
         mode_ff      <= 1'b0;
         rwin_ff      <= 16'd7;
         hthr_ff      <= 16'd768;
         zthr_ff      <= 16'd768;
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         tp_ff        <= '0;
         fp_ff        <= '0;
         tn_ff        <= '0;
         fnc_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            unique case (cfg_idx)
               REG_ENABLE: en_ff   <= csr_pwdata[0];
               REG_MODE:   mode_ff <= csr_pwdata[0];
               REG_WINDOW: rwin_ff <= csr_pwdata[15:0];
               REG_HTHR:   hthr_ff <= csr_pwdata[15:0];
               REG_ZTHR:   zthr_ff <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         tp_ff        <= tp_in;
         fp_ff        <= fp_in;
         tn_ff        <= tn_in;
         fnc_ff       <= fnc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff    <= start_in;
      pass_ff     <= pass_in;
      ci_ff       <= ci_in;
      j_ff        <= j_in;
      p_ff        <= p_in;
      lt_ff       <= lt_in;
      le_ff       <= le_in;
      x_ff        <= x_in;
      cand_ff     <= cand_in;
      med_ff      <= med_in;
      mad_ff      <= mad_in;
      repl_ff     <= repl_in;
      spk_ff      <= spk_in;
      outl_ff     <= outl_in;
      s_ff        <= s_in;
      q_ff        <= q_in;
      dq_ff       <= dq_in;
      d_ff        <= d_in;
      ss_ff       <= ss_in;
      lz_ff       <= lz_in;
      cx_ff       <= cx_in;
      dev_ff      <= dev_in;
      t2_ff       <= t2_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      hl_ff       <= hl_in;
      hr1_ff      <= hr1_in;
      hr_ff       <= hr_in;
      o_sample_ff <= o_sample_in;
      o_outl_ff   <= o_outl_in;
      o_tp_ff     <= o_tp_in;
      o_fp_ff     <= o_fp_in;
      o_tn_ff     <= o_tn_in;
      o_fn_ff     <= o_fn_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_sample      = o_sample_ff;
   assign rsp_replaced        = o_outl_ff;
   assign rsp_true_pos_count  = o_tp_ff;
   assign rsp_false_pos_count = o_fp_ff;
   assign rsp_true_neg_count  = o_tn_ff;
   assign rsp_false_neg_count = o_fn_ff;

   `SWOF_ASSERT_IMP(a_sweep_bound, clock, reset, state_ff == S_SWEEP, j_ff <= win_n)
   `SWOF_ASSERT_NEXT(a_cfg_clear, clock, reset, cfg_wr && cfg_hit, fill_ff == '0 && tp_ff == '0)
   `SWOF_ASSERT_IMP(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)

endmodule
